// ----- hw/rtl/wcar_pkg.sv -----
// wcar_pkg: shared constants and types for windowed_channel_average_rank.
// No dependencies.
`timescale 1ns / 1ps
package wcar_pkg;
   localparam int CHANNEL_COUNT = 6;
   localparam int SAMPLE_BITS   = 16;
   localparam int DAY_BITS      = 9;
   localparam int COUNT_BITS    = 10;
   localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
   localparam int ID_BITS       = 3;
   localparam int ID_W          = $clog2(CHANNEL_COUNT);
   localparam int IN_BITS       = DAY_BITS + CHANNEL_COUNT * SAMPLE_BITS;
   localparam int IN_BYTES_W    = ((IN_BITS + 7) / 8) * 8;
   localparam int OUT_BITS      = ID_BITS + SAMPLE_BITS;
   localparam int OUT_BYTES_W   = ((OUT_BITS + 7) / 8) * 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [DAY_BITS-1:0] RST_W0_START = DAY_BITS'(1);
   localparam logic [DAY_BITS-1:0] RST_W0_END   = DAY_BITS'(79);
   localparam logic [DAY_BITS-1:0] RST_W1_START = DAY_BITS'(355);
   localparam logic [DAY_BITS-1:0] RST_W1_END   = DAY_BITS'(365);
   localparam logic [1:0] REG_W0_START = 2'd0;
   localparam logic [1:0] REG_W0_END   = 2'd1;
   localparam logic [1:0] REG_W1_START = 2'd2;
   localparam logic [1:0] REG_W1_END   = 2'd3;

   typedef enum logic [1:0] {ST_ACCUM, ST_DIVIDE, ST_RANK, ST_EMIT} state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;
endpackage

// ----- hw/rtl/wcar_lane.sv -----
// wcar_lane: one channel's accumulator and serial restoring divider.
// Depends on wcar_pkg.
`timescale 1ns / 1ps
module wcar_lane import wcar_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [1:0]                    add_times,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  div_ctl_type                   ctl,
   input  logic [COUNT_BITS-1:0]         divisor,
   output logic signed [SAMPLE_BITS-1:0] mean
);
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SUM_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [COUNT_BITS:0] trial;
   logic signed [SUM_BITS-1:0] ext, qs;

   always_comb begin
      ext = SUM_BITS'(sample);
      sum_in = sum_ff;
      if (clear) sum_in = '0;
      else if (add_times == 2'd1) sum_in = sum_ff + ext;
      else if (add_times == 2'd2) sum_in = sum_ff + (ext <<< 1);
      quo_in = quo_ff; rem_in = rem_ff; neg_in = neg_ff; trial = '0;
      if (ctl.start) begin
         neg_in = sum_ff[SUM_BITS-1];
         quo_in = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
         rem_in = '0;
      end else if (ctl.busy) begin
         // one quotient bit per cycle
         trial = {rem_ff, quo_ff[SUM_BITS-1]};
         if (trial >= {1'b0, divisor}) begin
            rem_in = COUNT_BITS'(trial - {1'b0, divisor});
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = COUNT_BITS'(trial);
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
      end
      qs = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      mean = (divisor == '0) ? '0 : qs[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) sum_ff <= '0;
      else sum_ff <= sum_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end
endmodule

// ----- hw/rtl/wcar_rank.sv -----
// wcar_rank: ranking stage, ranks the lane averages by pairwise comparison.
// Depends on wcar_pkg.
`timescale 1ns / 1ps
module wcar_rank import wcar_pkg::*; (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] means [CHANNEL_COUNT],
   input  logic [ID_W-1:0]               pick,
   output logic [ID_BITS-1:0]            pick_id,
   output logic signed [SAMPLE_BITS-1:0] pick_mean
);
   logic [ID_W-1:0] slot_ff [CHANNEL_COUNT];
   logic signed [SAMPLE_BITS-1:0] mean_ff [CHANNEL_COUNT];
   logic [ID_W-1:0] rank [CHANNEL_COUNT];

   always_comb begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         rank[c] = '0;
         for (int k = 0; k < CHANNEL_COUNT; k++)
            if (means[k] > means[c] || (means[k] == means[c] && k < c))
               rank[c] = rank[c] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load)
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            slot_ff[rank[c]] <= ID_W'(c);
            mean_ff[rank[c]] <= means[c];
         end
   end

   assign pick_id   = ID_BITS'(slot_ff[pick]);
   assign pick_mean = mean_ff[pick];
endmodule

// ----- hw/rtl/windowed_channel_average_rank.sv -----
// windowed_channel_average_rank: top level, window match, lanes, ranking, output.
// Depends on wcar_pkg, wcar_lane, wcar_rank.
//  channel | ports            | payload
//  req     | req_t*           | tdata: day_index, samples 0..5; tlast: final_record
//  rsp     | rsp_t*           | tdata: channel_id, channel_mean; tuser: no_days_flag; tlast
//  csr     | csr_we/idx/wdata | four window bounds
// Ordinary records: one per cycle while req_tready is high. Final record: a serial
// divide (lane divider) and a ranking step, then six results, one per cycle
// while rsp_tready is high. Sync reset clears sums and count, restores windows.
`timescale 1ns / 1ps
module windowed_channel_average_rank import wcar_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_BYTES_W-1:0]  req_tdata,  // day_index, sample_zero..sample_five
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_BYTES_W-1:0] rsp_tdata,  // channel_id, channel_mean
   output logic                   rsp_tuser,  // no_days_flag
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [1:0]             csr_idx,
   input  logic [DAY_BITS-1:0]    csr_wdata
);
   logic [DAY_BITS-1:0] w0s_ff, w0e_ff, w1s_ff, w1e_ff;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   state_type st_ff, st_in;
   logic [$clog2(SUM_BITS+1)-1:0] step_ff, step_in;
   logic [ID_W-1:0] pos_ff, pos_in;
   logic acc, hit0, hit1, clear, load;
   logic [1:0] times;
   logic [DAY_BITS-1:0] day;
   div_ctl_type ctl;
   logic signed [SAMPLE_BITS-1:0] means [CHANNEL_COUNT];
   logic [ID_BITS-1:0] pid;
   logic signed [SAMPLE_BITS-1:0] pmean;

   always_ff @(posedge clock) begin
      if (reset) begin
         w0s_ff <= RST_W0_START; w0e_ff <= RST_W0_END;
         w1s_ff <= RST_W1_START; w1e_ff <= RST_W1_END;
      end else if (csr_we) begin
         case (csr_idx)
            REG_W0_START: w0s_ff <= csr_wdata;
            REG_W0_END:   w0e_ff <= csr_wdata;
            REG_W1_START: w1s_ff <= csr_wdata;
            REG_W1_END:   w1e_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign day  = req_tdata[DAY_BITS-1:0];
   assign hit0 = day >= w0s_ff && day <= w0e_ff;
   assign hit1 = day >= w1s_ff && day <= w1e_ff;
   assign acc  = req_tvalid && req_tready;

   always_comb begin
      // count saturates; second window add only if room left
      times = 2'd0;
      cnt_in = cnt_ff;
      if (acc) begin
         if (hit0 && cnt_ff != COUNT_MAX) begin
            times = 2'd1;
            if (hit1 && cnt_ff != COUNT_MAX - 1'b1) times = 2'd2;
         end else if (hit1 && cnt_ff != COUNT_MAX) times = 2'd1;
         cnt_in = cnt_ff + COUNT_BITS'(times);
      end
      st_in = st_ff; step_in = step_ff; pos_in = pos_ff;
      req_tready = 1'b0; rsp_tvalid = 1'b0; clear = 1'b0; load = 1'b0;
      ctl = '0;
      case (st_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
            if (acc && req_tlast) begin st_in = ST_DIVIDE; step_in = '0; end
         end
         ST_DIVIDE: begin
            ctl.start = (step_ff == '0);
            ctl.busy  = (step_ff != '0);
            step_in = step_ff + 1'b1;
            if (step_ff == ($clog2(SUM_BITS+1))'(SUM_BITS)) begin
               st_in = ST_RANK;
            end
         end
         ST_RANK: begin load = 1'b1; pos_in = '0; st_in = ST_EMIT; end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               pos_in = pos_ff + 1'b1;
               if (pos_ff == ID_W'(CHANNEL_COUNT - 1)) begin
                  st_in = ST_ACCUM; clear = 1'b1; cnt_in = '0;
               end
            end
         end
         default: st_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_ACCUM; cnt_ff <= '0; step_ff <= '0; pos_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; step_ff <= step_in; pos_ff <= pos_in;
      end
   end

   for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_lane
      wcar_lane u_lane (
         .clock, .reset, .clear, .add_times(times),
         .sample(req_tdata[DAY_BITS + c*SAMPLE_BITS +: SAMPLE_BITS]),
         .ctl, .divisor(cnt_ff), .mean(means[c])
      );
   end

   wcar_rank u_rank (
      .clock, .load, .means, .pick(pos_ff), .pick_id(pid), .pick_mean(pmean)
   );

   assign rsp_tdata = OUT_BYTES_W'({pmean, pid});
   assign rsp_tuser = (cnt_ff == '0);
   assign rsp_tlast = (pos_ff == ID_W'(CHANNEL_COUNT - 1));
endmodule

// ----- hw/rtl/wcar_checker.sv -----
// wcar_checker: port-level assertions for windowed_channel_average_rank.
// Depends on wcar_pkg; bound to the top level.
`timescale 1ns / 1ps
module wcar_checker import wcar_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast,
   input logic rsp_tuser
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input open while emitting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready) else $error("no return");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $past(rsp_tvalid) |-> $stable(rsp_tuser)) else $error("flag moved");
endmodule

bind windowed_channel_average_rank wcar_checker u_wcar_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tlast, .rsp_tuser
);
